/* rtl/core/ssfir_pkg.sv */
// Package for the same-size FIR line filter: default sizes, command codes,
// controller states and the command and status words between controller and datapath.
// Depends on nothing.
package ssfir_pkg;

	localparam int MAX_TAPS_DEF    = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int RES_BITS        = 36;
	localparam int TAP_COUNT_BITS  = 5;
	localparam int COEF_IDX_BITS   = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT,
		ST_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic push;
		logic flush_shift;
		logic coef_we;
		logic mac_step;
		logic out_load;
		logic out_last;
		logic line_clear;
	} dp_cmd_t;

	typedef struct packed {
		logic mac_last;
		logic out_busy;
	} dp_stat_t;

endpackage

/* rtl/core/ssfir_if.sv */
// Channel interfaces of the same-size FIR line filter: input words, result words
// and the tap count write channel. Depends on ssfir_pkg.
interface ssfir_in_if #(
	parameter int SAMPLE_BITS = ssfir_pkg::SAMPLE_BITS_DEF
);
	logic                                   valid;
	logic                                   ready;
	logic                                   command;
	logic [ssfir_pkg::COEF_IDX_BITS-1:0]    coef_index;
	logic signed [SAMPLE_BITS-1:0]          value;
	logic                                   last_sample;

	modport source (output valid, output command, output coef_index, output value,
		output last_sample, input ready);
	modport sink (input valid, input command, input coef_index, input value,
		input last_sample, output ready);
endinterface

interface ssfir_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ssfir_pkg::RES_BITS-1:0]  result;
	logic                                   last_result;

	modport source (output valid, output result, output last_result, input ready);
	modport sink (input valid, input result, input last_result, output ready);
endinterface

interface ssfir_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic [ssfir_pkg::TAP_COUNT_BITS-1:0]    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/ssfir_dp.sv */
// Datapath of the same-size FIR line filter: sample window, coefficient bank,
// one shared multiply-accumulate unit and the result register. Depends on ssfir_pkg.
module ssfir_dp #(
	parameter int MAX_TAPS    = ssfir_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = ssfir_pkg::SAMPLE_BITS_DEF,
	localparam int TW = $clog2(MAX_TAPS + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ssfir_pkg::dp_cmd_t                     cmd,
	output ssfir_pkg::dp_stat_t                    stat,
	input  logic [TW-1:0]                          taps,
	input  logic [ssfir_pkg::COEF_IDX_BITS-1:0]    coef_index,
	input  logic signed [SAMPLE_BITS-1:0]          value,
	output logic signed [ssfir_pkg::RES_BITS-1:0]  result,
	output logic                                   last_result,
	output logic                                   out_valid,
	input  logic                                   out_ready
);

	localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int RB = ssfir_pkg::RES_BITS;

	logic signed [SAMPLE_BITS-1:0]   win_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]   coef_q [MAX_TAPS];
	logic [IW-1:0]                   k_q;
	logic                            mac_last;
	logic signed [2*SAMPLE_BITS-1:0] prod_s1;
	logic                            vld_s1;
	logic                            first_s1;
	logic signed [RB-1:0]            acc_q;
	logic signed [RB-1:0]            result_q;
	logic                            last_q;
	logic                            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.line_clear) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.push || cmd.flush_shift) begin
			win_q[0] <= cmd.push ? value : '0;
			for (int i = 1; i < MAX_TAPS; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cmd.coef_we && (int'(coef_index) < MAX_TAPS)) begin
			coef_q[IW'(coef_index)] <= value;
		end
	end

	assign mac_last = (int'(k_q) + 1 >= int'(taps));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			vld_s1   <= cmd.mac_step;
			first_s1 <= cmd.mac_step && (k_q == '0);
			if (cmd.mac_step) begin
				k_q <= mac_last ? '0 : k_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_step) begin
			prod_s1 <= coef_q[k_q] * win_q[k_q];
		end
		if (vld_s1) begin
			acc_q <= (first_s1 ? '0 : acc_q) + RB'(prod_s1);
		end
		if (cmd.out_load) begin
			result_q <= acc_q;
			last_q   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.mac_last = mac_last;
	assign stat.out_busy = out_valid_q && !out_ready;
	assign result        = result_q;
	assign last_result   = last_q;
	assign out_valid     = out_valid_q;

endmodule

/* rtl/core/ssfir_ctrl.sv */
// Controller of the same-size FIR line filter: tap count register, line bookkeeping
// and the state machine that sequences pushes, flushes and the accumulate passes.
// Depends on ssfir_pkg.
module ssfir_ctrl #(
	parameter int MAX_TAPS = ssfir_pkg::MAX_TAPS_DEF,
	localparam int TW = $clog2(MAX_TAPS + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ssfir_pkg::TAP_COUNT_BITS-1:0]   cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   in_command,
	input  logic                                   in_last_sample,
	output ssfir_pkg::dp_cmd_t                     cmd,
	input  ssfir_pkg::dp_stat_t                    stat,
	output logic [TW-1:0]                          taps
);

	ssfir_pkg::ctrl_state_t state_q, state_d;

	logic [ssfir_pkg::TAP_COUNT_BITS-1:0] tap_q;
	logic [TW-1:0] eff_taps;
	logic [TW-1:0] eff_d;
	logic [TW-1:0] taps_q;
	logic [TW-1:0] d_q;
	logic [TW-1:0] ss_q;
	logic [TW-1:0] j_q;
	logic          last_q;
	logic          accept;
	logic          push_acc;
	logic          push_emit;
	logic          flush_emit;
	logic          final_res;

	always_comb begin
		if (tap_q == '0) begin
			eff_taps = TW'(1);
		end else if (int'(tap_q) > MAX_TAPS) begin
			eff_taps = TW'(MAX_TAPS);
		end else begin
			eff_taps = TW'(tap_q);
		end
	end

	assign eff_d      = eff_taps >> 1;
	assign in_ready   = (state_q == ssfir_pkg::ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign push_acc   = accept && (in_command == ssfir_pkg::CMD_PUSH);
	assign push_emit  = (ss_q >= eff_d);
	assign flush_emit = (int'(ss_q) + int'(j_q) + 1) > int'(d_q);
	assign final_res  = last_q && (j_q == d_q);
	assign cfg_ready  = 1'b1;
	assign taps       = taps_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssfir_pkg::ST_IDLE: begin
				if (push_acc) begin
					if (push_emit) begin
						state_d = ssfir_pkg::ST_MAC;
					end else if (in_last_sample) begin
						state_d = ssfir_pkg::ST_FLUSH;
					end
				end
			end
			ssfir_pkg::ST_MAC: begin
				if (stat.mac_last) begin
					state_d = ssfir_pkg::ST_DRAIN;
				end
			end
			ssfir_pkg::ST_DRAIN: begin
				state_d = ssfir_pkg::ST_EMIT;
			end
			ssfir_pkg::ST_EMIT: begin
				if (!stat.out_busy) begin
					if (last_q && !final_res) begin
						state_d = ssfir_pkg::ST_FLUSH;
					end else begin
						state_d = ssfir_pkg::ST_IDLE;
					end
				end
			end
			ssfir_pkg::ST_FLUSH: begin
				if (flush_emit) begin
					state_d = ssfir_pkg::ST_MAC;
				end
			end
			default: begin
				state_d = ssfir_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ssfir_pkg::ST_IDLE: begin
				cmd.push    = push_acc;
				cmd.coef_we = accept && (in_command == ssfir_pkg::CMD_LOAD);
			end
			ssfir_pkg::ST_MAC: begin
				cmd.mac_step = 1'b1;
			end
			ssfir_pkg::ST_EMIT: begin
				cmd.out_load   = !stat.out_busy;
				cmd.out_last   = final_res;
				cmd.line_clear = !stat.out_busy && final_res;
			end
			ssfir_pkg::ST_FLUSH: begin
				cmd.flush_shift = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssfir_pkg::ST_IDLE;
			tap_q   <= ssfir_pkg::TAP_COUNT_BITS'(1);
			taps_q  <= TW'(1);
			d_q     <= '0;
			ss_q    <= '0;
			j_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				tap_q <= cfg_data;
			end
			if (push_acc) begin
				taps_q <= eff_taps;
				d_q    <= eff_d;
				last_q <= in_last_sample;
				j_q    <= '0;
				if (int'(ss_q) < MAX_TAPS) begin
					ss_q <= ss_q + TW'(1);
				end
			end
			if (cmd.flush_shift) begin
				j_q <= j_q + TW'(1);
			end
			if (cmd.line_clear) begin
				ss_q   <= '0;
				j_q    <= '0;
				last_q <= 1'b0;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) j_q <= d_q)
		else $error("Flush step count has passed half the tap count.");

	assert property (@(posedge clk) disable iff (!arst_n) int'(ss_q) <= MAX_TAPS)
		else $error("Sample count has run past its saturation value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssfir_pkg::ST_FLUSH) |-> last_q)
		else $error("Flush is running without a last sample in the line.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push_acc && push_emit) |=> (state_q == ssfir_pkg::ST_MAC))
		else $error("A sample that completes a result did not start an accumulate pass.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.line_clear |=> (ss_q == '0) && in_ready)
		else $error("Line end did not return the controller to an empty line.");

endmodule

/* rtl/core/same_size_fir_line_filter_unit.sv */
// Same-size FIR line filter: centred, zero-padded true convolution of one line.
// A load writes its coefficient. A push that completes a word starts an accumulate pass
// over T taps, a drain and an emit, T being the tap count clamped to 1..MAX_TAPS. After
// the last sample each flushed word takes a zero shift and its own pass, with zeros shifted
// in ahead of the first flushed word of a short line; a receiver holding off stalls it.
// Reset clears the window, coefficients and line state, sets one tap and leaves it ready.
module same_size_fir_line_filter_unit #(
	parameter int MAX_TAPS    = ssfir_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = ssfir_pkg::SAMPLE_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	ssfir_cfg_if.sink     cfg,
	ssfir_in_if.sink      in_ch,
	ssfir_out_if.source   out_ch
);

	localparam int TW = $clog2(MAX_TAPS + 1);

	ssfir_pkg::dp_cmd_t  cmd;
	ssfir_pkg::dp_stat_t stat;
	logic [TW-1:0]       taps;
	logic                in_ready;
	logic                cfg_ready;

	ssfir_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg.valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg.data),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ready),
		.in_command     (in_ch.command),
		.in_last_sample (in_ch.last_sample),
		.cmd            (cmd),
		.stat           (stat),
		.taps           (taps)
	);

	ssfir_dp #(
		.MAX_TAPS    (MAX_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.taps        (taps),
		.coef_index  (in_ch.coef_index),
		.value       (in_ch.value),
		.result      (out_ch.result),
		.last_result (out_ch.last_result),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready)
	);

	assign in_ch.ready = in_ready;
	assign cfg.ready   = cfg_ready;

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for same_size_fir_line_filter_unit: a convolution predictor in the bench,
// directed corner lines, random line traffic, random input gaps and random receiver stalls.
// Depends on ssfir_pkg, the ssfir channel interfaces and the filter unit itself.
module tb;

	localparam int TAPS           = ssfir_pkg::MAX_TAPS_DEF;
	localparam int SBITS          = ssfir_pkg::SAMPLE_BITS_DEF;
	localparam int RES_BITS       = ssfir_pkg::RES_BITS;
	localparam int TAP_COUNT_BITS = ssfir_pkg::TAP_COUNT_BITS;
	localparam int COEF_IDX_BITS  = ssfir_pkg::COEF_IDX_BITS;
	localparam int SETTLE_CYCLES  = 2 * (TAPS + 3) + 8;
	localparam int CYCLE_LIMIT    = 1_000_000;

	typedef struct {
		logic signed [RES_BITS-1:0] sum;
		logic                       last;
	} filt_word_t;

	logic clk = 1'b0;
	logic arst_n;

	ssfir_cfg_if                    cfg();
	ssfir_in_if #(.SAMPLE_BITS(SBITS)) in_ch();
	ssfir_out_if                    out_ch();

	filt_word_t                pending_words[$];
	logic signed [SBITS-1:0]   line_window[TAPS];
	logic signed [SBITS-1:0]   coef_bank[TAPS];
	int unsigned               line_fill;
	logic [TAP_COUNT_BITS-1:0] tap_setting;

	int unsigned error_count    = 0;
	int unsigned words_sent     = 0;
	int unsigned cycle_count    = 0;
	bit          tx_idling      = 1'b1;
	bit          rx_idling      = 1'b1;
	int unsigned rx_hold_cycles = 0;

	same_size_fir_line_filter_unit #(
		.MAX_TAPS(TAPS),
		.SAMPLE_BITS(SBITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned taps_in_use();
		int unsigned t;
		t = tap_setting;
		if (t == 0) t = 1;
		if (t > TAPS) t = TAPS;
		return t;
	endfunction

	function automatic void shift_window(logic signed [SBITS-1:0] v);
		for (int i = TAPS - 1; i > 0; i--) line_window[i] = line_window[i-1];
		line_window[0] = v;
	endfunction

	function automatic logic signed [RES_BITS-1:0] tap_sum(int unsigned taps);
		logic signed [RES_BITS-1:0] acc;
		acc = '0;
		for (int k = 0; k < taps; k++) acc += coef_bank[k] * line_window[k];
		return acc;
	endfunction

	function automatic void clear_line();
		for (int i = 0; i < TAPS; i++) line_window[i] = '0;
		line_fill = 0;
	endfunction

	// Each sample that follows at least half a window of samples yields the word half a window
	// back; the closing sample also pushes zeros through to produce the words still owed for the end of the line.
	function automatic void convolve_sample(logic signed [SBITS-1:0] v, logic last);
		int unsigned taps, half, n, made;
		filt_word_t w;
		taps = taps_in_use();
		half = taps / 2;
		made = 0;
		shift_window(v);
		n = line_fill;
		if (line_fill < TAPS) line_fill++;
		if (n >= half) begin
			w.sum = tap_sum(taps);
			w.last = 1'b0;
			pending_words.push_back(w);
			made++;
		end
		if (last) begin
			for (int unsigned j = 1; j <= half; j++) begin
				shift_window('0);
				if (line_fill + j > half) begin
					w.sum = tap_sum(taps);
					w.last = 1'b0;
					pending_words.push_back(w);
					made++;
				end
			end
			if (made > 0) begin
				w = pending_words.pop_back();
				w.last = 1'b1;
				pending_words.push_back(w);
			end
			clear_line();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filt_word_t want;
		if (!arst_n) begin
			clear_line();
			for (int i = 0; i < TAPS; i++) coef_bank[i] = '0;
			tap_setting = TAP_COUNT_BITS'(1);
		end else begin
			if (cfg.valid && cfg.ready) tap_setting = cfg.data;
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.command == ssfir_pkg::CMD_LOAD) begin
					coef_bank[in_ch.coef_index] = in_ch.value;
				end else begin
					convolve_sample(in_ch.value, in_ch.last_sample);
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_words.size() == 0) begin
					$error("unexpected word: result %0d, last_result %0b",
						out_ch.result, out_ch.last_result);
					error_count++;
				end else begin
					want = pending_words.pop_front();
					if (out_ch.result !== want.sum) begin
						$error("result: expected %0d, got %0d", want.sum, out_ch.result);
						error_count++;
					end
					if (out_ch.last_result !== want.last) begin
						$error("last_result: expected %0b, got %0b", want.last,
							out_ch.last_result);
						error_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL same_size_fir_line_filter_unit");
			$finish;
		end
	end

	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The receiver: a long hold-off when one is requested, otherwise random stalls while rx_idling is set.
	initial begin
		int unsigned stall;
		stall = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				rx_hold_cycles--;
			end else if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
				if (rx_idling) stall = idle_length();
			end
		end
	end

	task automatic send_word(logic cmd, logic [COEF_IDX_BITS-1:0] idx,
		logic signed [SBITS-1:0] v, logic last);
		int unsigned gap;
		gap = tx_idling ? idle_length() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.command     <= cmd;
		in_ch.coef_index  <= idx;
		in_ch.value       <= v;
		in_ch.last_sample <= last;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
	endtask

	task automatic load(logic [COEF_IDX_BITS-1:0] idx, logic signed [SBITS-1:0] v);
		send_word(ssfir_pkg::CMD_LOAD, idx, v, 1'($urandom_range(0, 1)));
	endtask

	task automatic push(logic signed [SBITS-1:0] v, logic last);
		send_word(ssfir_pkg::CMD_PUSH, COEF_IDX_BITS'($urandom_range(0, TAPS - 1)), v, last);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_taps(logic [TAP_COUNT_BITS-1:0] taps);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.data  <= taps;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic signed [SBITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(SBITS-1){1'b0}}};
			1: return {1'b0, {(SBITS-1){1'b1}}};
			2: return '0;
			default: return SBITS'($urandom);
		endcase
	endfunction

	function automatic logic [TAP_COUNT_BITS-1:0] pick_taps();
		case ($urandom_range(0, 19))
			0: return TAP_COUNT_BITS'(0);
			1: return TAP_COUNT_BITS'($urandom_range(TAPS + 1, 31));
			2: return TAP_COUNT_BITS'(TAPS);
			3: return TAP_COUNT_BITS'(1);
			default: return TAP_COUNT_BITS'($urandom_range(1, TAPS));
		endcase
	endfunction

	function automatic int unsigned line_length();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 6) return $urandom_range(1, 12);
		if (roll < 9) return $urandom_range(13, 24);
		return $urandom_range(25, 40);
	endfunction

	// With reset coefficients every word is zero and a single tap gives no delay.
	task automatic test_reset_state();
		push(16'sd1234, 1'b0);
		push(-16'sd1, 1'b1);
	endtask

	// A tap count of zero acts as one and anything above the maximum acts as the maximum,
	// so the two-sample line below is shorter than half the window.
	task automatic test_tap_extremes();
		write_taps(TAP_COUNT_BITS'(0));
		load(COEF_IDX_BITS'(0), -16'sd32768);
		push(-16'sd32768, 1'b1);
		write_taps(TAP_COUNT_BITS'(31));
		load(COEF_IDX_BITS'(15), 16'sd32767);
		load(COEF_IDX_BITS'(8), -16'sd1);
		push(16'sd32767, 1'b0);
		push(-16'sd32768, 1'b1);
	endtask

	// The tap count changes in the middle of a line while the block is idle.
	task automatic test_mid_line_change();
		write_taps(TAP_COUNT_BITS'(3));
		load(COEF_IDX_BITS'(1), 16'sd7);
		load(COEF_IDX_BITS'(2), -16'sd3);
		push(16'sd100, 1'b0);
		push(-16'sd200, 1'b0);
		push(16'sd300, 1'b0);
		write_taps(TAP_COUNT_BITS'(5));
		push(16'sd5, 1'b0);
		push(-16'sd6, 1'b1);
	endtask

	// The receiver holds off while a long line streams in without gaps.
	task automatic test_output_backpressure();
		write_taps(TAP_COUNT_BITS'(8));
		tx_idling = 1'b0;
		rx_hold_cycles = 300;
		for (int s = 1; s <= 40; s++) push(rand_sample(), s == 40);
		wait_drained();
		tx_idling = 1'b1;
	endtask

	task automatic test_random_lines(int unsigned quota);
		int unsigned stop_at, len;
		bit broken;
		stop_at = words_sent + quota;
		while (words_sent < stop_at) begin
			tx_idling = $urandom_range(0, 3) != 0;
			rx_idling = $urandom_range(0, 3) != 0;
			write_taps(pick_taps());
			repeat ($urandom_range(0, 5))
				load(COEF_IDX_BITS'($urandom_range(0, TAPS - 1)), rand_sample());
			repeat ($urandom_range(1, 4)) begin
				len = line_length();
				broken = $urandom_range(0, 7) == 0;
				for (int s = 1; s <= len; s++) begin
					if ($urandom_range(0, 19) == 0)
						load(COEF_IDX_BITS'($urandom_range(0, TAPS - 1)), rand_sample());
					push(rand_sample(), s == len && !broken);
				end
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg.valid         <= 1'b0;
		cfg.data          <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.command     <= ssfir_pkg::CMD_LOAD;
		in_ch.coef_index  <= '0;
		in_ch.value       <= '0;
		in_ch.last_sample <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_tap_extremes();
		test_mid_line_change();
		test_output_backpressure();
		test_random_lines(360);

		wait_drained();
		if (error_count == 0 && pending_words.size() == 0) begin
			$display("PASS same_size_fir_line_filter_unit");
		end else begin
			$display("FAIL same_size_fir_line_filter_unit");
		end
		$finish;
	end

endmodule
